// ===== sv/lcc_pkg.sv =====
// lcc_pkg: shared types and constants of the lane color classifier.
// No dependencies; used by lcc_front, lcc_back and the top level.
`default_nettype none

package lcc_pkg;

  localparam int TALLY_W = 20;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // minimum S and V for a pixel to be counted
  localparam logic [7:0] SV_MIN = 8'd100;
  // tally that a lane color must exceed to be reported
  localparam logic [TALLY_W-1:0] COUNT_MIN = TALLY_W'(100);

  // color codes of a result
  localparam logic [1:0] COLOR_NONE = 2'd0;
  localparam logic [1:0] COLOR_RED  = 2'd1;
  localparam logic [1:0] COLOR_BLUE = 2'd2;

  // Hue numerator N = 60*off + diff, half-degree hue q = N / (2*diff).
  // q >= k  <=>  N >= 2k*diff, so each hue bound is a multiple of diff.
  localparam int HUE_SCALE  = 60;
  localparam int RED_LO_MUL = 40;   // q >= 20
  localparam int RED_HI_MUL = 82;   // q <= 40
  localparam int RED_WR_MUL = 400;  // q >= 200 (hue 170..180 after wrap)
  localparam int BLU_LO_MUL = 280;  // q >= 140
  localparam int BLU_HI_MUL = 322;  // q <= 160
  // S >= 100  <=>  510*diff >= 199*v
  localparam int SAT_DIFF_MUL = 510;
  localparam int SAT_V_MUL    = 199;

  typedef struct packed {
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [1:0]         lane_code;
    logic [TALLY_W-1:0] red_total;
    logic [TALLY_W-1:0] blue_total;
  } out_t;

  // per-pixel verdict passed from front to back
  typedef struct packed {
    logic red_hit;
    logic blue_hit;
    logic last;
  } cls_t;

endpackage

`default_nettype wire

// ===== sv/lcc_fifo.sv =====
// lcc_fifo: small synchronous queue with a combinational head.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module lcc_fifo #(
  parameter int WIDTH      = 3,
  parameter int DEPTH_LOG2 = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG2-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [DEPTH_LOG2:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == (DEPTH_LOG2+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcc_front.sv =====
// lcc_front: two-stage pixel classifier (max/min/hue offset, then thresholds).
// Depends on lcc_pkg.
`default_nettype none

module lcc_front import lcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  output logic      cls_vld,
  output cls_t      cls_data,
  input  wire logic cls_full
);

  // stage 1 registers
  logic        s1_vld_r, s1_vld_nxt;
  logic [7:0]  s1_v_r, s1_diff_r;
  logic [10:0] s1_off_r;
  logic        s1_last_r;
  // stage 2 registers
  logic        s2_vld_r, s2_vld_nxt;
  cls_t        s2_cls_r, s2_cls_nxt;

  logic        s1_rdy, s2_rdy, s1_load, s2_load;
  logic [7:0]  v, mn, diff;
  logic [10:0] off;
  logic [16:0] num, d17;
  logic        sv_ok, red_q, blue_q;

  assign s2_rdy  = !s2_vld_r || !cls_full;
  assign s1_rdy  = !s1_vld_r || s2_rdy;
  assign in_full = !s1_rdy;
  assign s1_load = in_push && s1_rdy;
  assign s2_load = s1_vld_r && s2_rdy;

  // stage 1: value, spread and hue offset (off = hue numerator + diff, 0..6*diff)
  always_comb begin
    v  = in_data.pix_red;
    mn = in_data.pix_red;
    if (in_data.pix_green > v)  v  = in_data.pix_green;
    if (in_data.pix_blue > v)   v  = in_data.pix_blue;
    if (in_data.pix_green < mn) mn = in_data.pix_green;
    if (in_data.pix_blue < mn)  mn = in_data.pix_blue;
    diff = v - mn;
    priority if (v == in_data.pix_red) begin
      off = 11'(in_data.pix_green) + 11'(diff) - 11'(in_data.pix_blue);
    end else if (v == in_data.pix_green) begin
      off = 11'(in_data.pix_blue) + (11'(diff) << 1) + 11'(diff)
            - 11'(in_data.pix_red);
    end else begin
      off = 11'(in_data.pix_red) + (11'(diff) << 2) + 11'(diff)
            - 11'(in_data.pix_green);
    end
  end

  // stage 2: saturation and hue windows as products against diff and v
  always_comb begin
    d17   = 17'(s1_diff_r);
    num   = 17'(s1_off_r) * 17'(HUE_SCALE) + d17;
    sv_ok = (s1_v_r >= SV_MIN) &&
            (d17 * 17'(SAT_DIFF_MUL) >= 17'(s1_v_r) * 17'(SAT_V_MUL));
    red_q = (num >= d17 * 17'(RED_LO_MUL) && num < d17 * 17'(RED_HI_MUL)) ||
            (num >= d17 * 17'(RED_WR_MUL));
    blue_q = (num >= d17 * 17'(BLU_LO_MUL)) && (num < d17 * 17'(BLU_HI_MUL));
    // grey pixels have S = 0 and are rejected by sv_ok
    s2_cls_nxt.red_hit  = sv_ok && red_q;
    s2_cls_nxt.blue_hit = sv_ok && !red_q && blue_q;
    s2_cls_nxt.last     = s1_last_r;
  end

  always_comb begin
    s1_vld_nxt = s1_load || (s1_vld_r && !s2_rdy);
    s2_vld_nxt = s2_load || (s2_vld_r && cls_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_v_r    <= v;
      s1_diff_r <= diff;
      s1_off_r  <= off;
      s1_last_r <= in_data.frame_last;
    end
    if (s2_load) begin
      s2_cls_r <= s2_cls_nxt;
    end
  end

  assign cls_vld  = s2_vld_r;
  assign cls_data = s2_cls_r;

endmodule

`default_nettype wire

// ===== sv/lcc_back.sv =====
// lcc_back: saturating red/blue tallies and the end-of-region report.
// Depends on lcc_pkg.
`default_nettype none

module lcc_back import lcc_pkg::*; #(
  parameter int MAX_PIXELS = 524288
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cls_empty,
  input  wire cls_t cls_data,
  output logic      cls_pop,
  output logic      res_push,
  output out_t      res_data,
  input  wire logic res_full
);

  localparam int TALLY_CAP_I = (MAX_PIXELS > int'(TALLY_MAX)) ? int'(TALLY_MAX) : MAX_PIXELS;
  localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(TALLY_CAP_I);

  logic [TALLY_W-1:0] red_r, red_nxt, blue_r, blue_nxt;
  logic [TALLY_W-1:0] red_upd, blue_upd;

  // a region's last pixel waits until the result queue has room
  assign cls_pop  = !cls_empty && (!cls_data.last || !res_full);
  assign res_push = cls_pop && cls_data.last;

  always_comb begin
    red_upd  = red_r;
    blue_upd = blue_r;
    if (cls_data.red_hit) begin
      red_upd = (red_r < TALLY_CAP) ? red_r + 1'b1 : TALLY_CAP;
    end
    if (cls_data.blue_hit) begin
      blue_upd = (blue_r < TALLY_CAP) ? blue_r + 1'b1 : TALLY_CAP;
    end

    res_data.red_total  = red_upd;
    res_data.blue_total = blue_upd;
    priority if (red_upd > blue_upd && red_upd > COUNT_MIN) begin
      res_data.lane_code = COLOR_RED;
    end else if (blue_upd > COUNT_MIN) begin
      res_data.lane_code = COLOR_BLUE;
    end else begin
      res_data.lane_code = COLOR_NONE;
    end

    red_nxt  = red_r;
    blue_nxt = blue_r;
    if (cls_pop) begin
      red_nxt  = cls_data.last ? '0 : red_upd;
      blue_nxt = cls_data.last ? '0 : blue_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r  <= '0;
      blue_r <= '0;
    end else begin
      red_r  <= red_nxt;
      blue_r <= blue_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lane_color_classifier_unit.sv =====
// lane_color_classifier_unit: top level of the lane color classifier.
// Depends on lcc_pkg, lcc_front, lcc_fifo and lcc_back.
//
// Usage
//   Input queue: drive in_data (blue, green, red, frame_last) and raise
//   in_push; a request is taken at a rising edge with in_push high and
//   in_full low. One pixel can be taken every cycle while in_full stays low.
//   Result queue: while out_empty is low, out_data holds the oldest report
//   (color code, red and blue totals); raise out_pop to take it.
//   A report is produced only for a pixel marked frame_last, and the
//   tallies restart from zero for the next region.
// Path: a report for a region's last pixel passes the two classifier stages
//   and the verdict queue, then one tally update writes it into the result queue.
// Throughput: one pixel per cycle while the result queue has room and nothing stalls,
//   set by the two-stage front pipeline and the registered tally update in the back end.
// Stalls: when out_pop is held low, reports collect in the result queue;
//   once it is full the back end stops at the next last pixel, the verdict
//   queue fills, the front stalls and in_full rises. No request is dropped.
// Reset: rst_n low (synchronous) empties all queues and stages and clears
//   both tallies.
`default_nettype none

module lane_color_classifier_unit import lcc_pkg::*; #(
  parameter int MAX_PIXELS = 524288
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input queue
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  // result queue
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  localparam int CLS_DEPTH_LOG2 = 2;
  localparam int RES_DEPTH_LOG2 = 1;

  logic cls_vld, cls_q_full, cls_q_empty, cls_pop;
  cls_t cls_in, cls_out;
  logic res_push, res_full;
  out_t res_in;

  // front: classify each pixel
  lcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cls_vld  (cls_vld),
    .cls_data (cls_in),
    .cls_full (cls_q_full)
  );

  // verdict queue between front and back
  lcc_fifo #(
    .WIDTH      ($bits(cls_t)),
    .DEPTH_LOG2 (CLS_DEPTH_LOG2)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cls_vld),
    .wr_data (cls_in),
    .full    (cls_q_full),
    .pop     (cls_pop),
    .rd_data (cls_out),
    .empty   (cls_q_empty)
  );

  // back: tallies and region report
  lcc_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_empty (cls_q_empty),
    .cls_data  (cls_out),
    .cls_pop   (cls_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  // result queue toward the consumer
  lcc_fifo #(
    .WIDTH      ($bits(out_t)),
    .DEPTH_LOG2 (RES_DEPTH_LOG2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire
